FILE: rtl/alu8sf_pkg.sv
// Shared types for the eight-bit ALU with shifts and flags.
// Operation codes, flag record and stream widths; no dependencies.
package alu8sf_pkg;

   // Stream widths, padded to whole bytes
   localparam int ReqDataWidth = 24;
   localparam int RspDataWidth = 16;

   // Operation codes as carried in the request beat
   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_ADC  = 4'd1,
      OP_SUB  = 4'd2,
      OP_SBC  = 4'd3,
      OP_AND  = 4'd4,
      OP_XOR  = 4'd5,
      OP_OR   = 4'd6,
      OP_CP   = 4'd7,
      OP_RLC  = 4'd8,
      OP_RRC  = 4'd9,
      OP_RL   = 4'd10,
      OP_RR   = 4'd11,
      OP_SLA  = 4'd12,
      OP_SRA  = 4'd13,
      OP_SWAP = 4'd14,
      OP_SRL  = 4'd15
   } alu_op_type;

   // Condition flags, most significant first as in the flag register
   typedef struct packed {
      logic zero;
      logic subtract;
      logic half;
      logic carry;
   } flags_type;

endpackage

FILE: rtl/alu8sf_core.sv
// Combinational datapath of the eight-bit ALU: one operation, result and flags.
// Depends on alu8sf_pkg for the operation codes and the flag record.
module alu8sf_core (
   input  alu8sf_pkg::alu_op_type op,
   input  logic [7:0]             operand_a,
   input  logic [7:0]             operand_b,
   input  logic                   cin,
   output logic [7:0]             result,
   output alu8sf_pkg::flags_type  flags
);
   import alu8sf_pkg::*;

   logic       carry_use;
   logic [8:0] sum9;
   logic [4:0] hsum5;
   logic [8:0] diff9;
   logic [4:0] hdiff5;
   logic [7:0] zero_src;

   // Kept carry feeds the adder and subtractor only for ADC and SBC; RL and RR shift it in
   assign carry_use = ((op == OP_ADC) || (op == OP_SBC)) && cin;

   // Adder and subtractor, full byte and low nibble
   assign sum9   = {1'b0, operand_a} + {1'b0, operand_b} + {8'd0, carry_use};
   assign hsum5  = {1'b0, operand_a[3:0]} + {1'b0, operand_b[3:0]} + {4'd0, carry_use};
   assign diff9  = {1'b0, operand_a} - {1'b0, operand_b} - {8'd0, carry_use};
   assign hdiff5 = {1'b0, operand_a[3:0]} - {1'b0, operand_b[3:0]} - {4'd0, carry_use};

   // Select result and flags by operation
   always_comb begin
      result         = operand_a;
      zero_src       = operand_a;
      flags.subtract = 1'b0;
      flags.half     = 1'b0;
      flags.carry    = 1'b0;
      case (op)
         OP_ADD, OP_ADC: begin
            result      = sum9[7:0];
            zero_src    = sum9[7:0];
            flags.half  = hsum5[4];
            flags.carry = sum9[8];
         end
         OP_SUB, OP_SBC: begin
            result         = diff9[7:0];
            zero_src       = diff9[7:0];
            flags.subtract = 1'b1;
            flags.half     = hdiff5[4];
            flags.carry    = diff9[8];
         end
         OP_CP: begin
            // compare: flags of a subtract, destination passes through
            result         = operand_a;
            zero_src       = diff9[7:0];
            flags.subtract = 1'b1;
            flags.half     = hdiff5[4];
            flags.carry    = diff9[8];
         end
         OP_AND: begin
            result     = operand_a & operand_b;
            zero_src   = operand_a & operand_b;
            flags.half = 1'b1;
         end
         OP_XOR: begin
            result   = operand_a ^ operand_b;
            zero_src = operand_a ^ operand_b;
         end
         OP_OR: begin
            result   = operand_a | operand_b;
            zero_src = operand_a | operand_b;
         end
         OP_RLC: begin
            result      = {operand_a[6:0], operand_a[7]};
            zero_src    = {operand_a[6:0], operand_a[7]};
            flags.carry = operand_a[7];
         end
         OP_RRC: begin
            result      = {operand_a[0], operand_a[7:1]};
            zero_src    = {operand_a[0], operand_a[7:1]};
            flags.carry = operand_a[0];
         end
         OP_RL: begin
            result      = {operand_a[6:0], cin};
            zero_src    = {operand_a[6:0], cin};
            flags.carry = operand_a[7];
         end
         OP_RR: begin
            result      = {cin, operand_a[7:1]};
            zero_src    = {cin, operand_a[7:1]};
            flags.carry = operand_a[0];
         end
         OP_SLA: begin
            result      = {operand_a[6:0], 1'b0};
            zero_src    = {operand_a[6:0], 1'b0};
            flags.carry = operand_a[7];
         end
         OP_SRA: begin
            // sign bit is kept
            result      = {operand_a[7], operand_a[7:1]};
            zero_src    = {operand_a[7], operand_a[7:1]};
            flags.carry = operand_a[0];
         end
         OP_SWAP: begin
            result   = {operand_a[3:0], operand_a[7:4]};
            zero_src = {operand_a[3:0], operand_a[7:4]};
         end
         OP_SRL: begin
            result      = {1'b0, operand_a[7:1]};
            zero_src    = {1'b0, operand_a[7:1]};
            flags.carry = operand_a[0];
         end
         default: begin
            result   = operand_a;
            zero_src = operand_a;
         end
      endcase
      flags.zero = (zero_src == 8'd0);
   end

endmodule

FILE: rtl/alu8_with_shifts_and_flags.sv
// Top level of the eight-bit ALU with shifts and flags: input register,
// datapath, result register and kept flag register.
// Depends on alu8sf_pkg and alu8sf_core.
//
// Usage:
//   The request stream carries one operation per beat (code, destination
//   byte, source byte); the response stream returns one beat per request,
//   in order, with the result byte and the four flags.
//   A request beat is captured in an input register; the datapath works on
//   it from there, and when the input stage advances the result register
//   and the flag register are loaded together; rsp_tvalid rises as the
//   result register is loaded. Throughput is one operation per cycle
//   while responses are taken; the only link between beats is the kept
//   carry, read from the flag register written by the beat before.
//   When the receiver stalls, the response beat is held, the input register
//   fills, and req_tready drops until the response is taken.
//   Reset empties both registers and clears the flags to zero.
module alu8_with_shifts_and_flags (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // cmd [3:0], operand_a [11:4], operand_b [19:12], zero [23:20]
   input  logic [alu8sf_pkg::ReqDataWidth-1:0]  req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // result [7:0], flag_zero [8], flag_subtract [9], flag_half [10],
   // flag_carry [11], zero [15:12]
   output logic [alu8sf_pkg::RspDataWidth-1:0]  rsp_tdata
);
   import alu8sf_pkg::*;

   logic       in_valid_ff, in_valid_in;
   alu_op_type op_ff;
   logic [7:0] a_ff;
   logic [7:0] b_ff;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] result_ff;
   flags_type  out_flags_ff;
   flags_type  flag_ff;
   logic [7:0] core_result;
   flags_type  core_flags;
   logic       advance;
   logic       req_beat;

   // Move the input stage on when the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   assign in_valid_in  = req_beat || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flag_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            flag_ff <= core_flags;
         end
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (req_beat) begin
         op_ff <= alu_op_type'(req_tdata[3:0]);
         a_ff  <= req_tdata[11:4];
         b_ff  <= req_tdata[19:12];
      end
   end

   alu8sf_core u_core (
      .op        (op_ff),
      .operand_a (a_ff),
      .operand_b (b_ff),
      .cin       (flag_ff.carry),
      .result    (core_result),
      .flags     (core_flags)
   );

   // Load the result register
   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff    <= core_result;
         out_flags_ff <= core_flags;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_flags_ff.carry, out_flags_ff.half,
                        out_flags_ff.subtract, out_flags_ff.zero, result_ff};

endmodule

FILE: rtl/alu8sf_checker.sv
// Port-level checks for the eight-bit ALU with shifts and flags, and the
// bind that attaches them to the top level. Depends on alu8sf_pkg.
module alu8sf_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [alu8sf_pkg::RspDataWidth-1:0]  rsp_tdata
);
   import alu8sf_pkg::*;

   // Hold a stalled response beat
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response beat dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // Outside subtract and compare, the zero flag follows the result byte
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[9] |-> rsp_tdata[8] == (rsp_tdata[7:0] == 8'd0))
      else $error("zero flag disagrees with result byte");

   // A response from an empty pipeline follows a request beat through the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) && !$past(reset) && !$past(reset, 2)
         |-> $past(req_tvalid && req_tready, 2))
      else $error("response beat without matching request beat");

endmodule

bind alu8_with_shifts_and_flags alu8sf_checker u_alu8sf_checker (.*);
